// File: src/utf8d_pkg.sv
// Shared types, codes and constants for the UTF-8 stream decoder.
// No dependencies; used by utf8d_step and utf8_stream_decoder_top.
package utf8d_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 31;
  localparam int unsigned LenW    = 3;
  localparam int unsigned StatusW = 2;

  // Output bus widths: code point and length in tdata, padded to whole bytes.
  localparam int unsigned OutPayW   = CpW + LenW;
  localparam int unsigned OutTdataW = ((OutPayW + 7) / 8) * 8;

  // Lead byte thresholds and payload masks of the six-byte form.
  localparam logic [ByteW-1:0] LeadMin6  = 8'hFC;
  localparam logic [ByteW-1:0] LeadMin5  = 8'hF8;
  localparam logic [ByteW-1:0] LeadMin4  = 8'hF0;
  localparam logic [ByteW-1:0] LeadMin3  = 8'hE0;
  localparam logic [ByteW-1:0] LeadMin2  = 8'hC0;
  localparam logic [ByteW-1:0] ContMin   = 8'h80;
  localparam logic [ByteW-1:0] InvalidMin = 8'hFE;
  localparam logic [ByteW-1:0] ContMask  = 8'h3F;
  localparam logic [ByteW-1:0] Lead2Mask = 8'h1F;
  localparam logic [ByteW-1:0] Lead3Mask = 8'h0F;
  localparam logic [ByteW-1:0] Lead4Mask = 8'h07;
  localparam logic [ByteW-1:0] Lead5Mask = 8'h03;
  localparam logic [ByteW-1:0] Lead6Mask = 8'h01;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_LEAD = 2'd1,
    STATUS_BAD_CONT = 2'd2
  } status_e;

  // One decoded result, plus a flag saying whether the byte produced one.
  typedef struct packed {
    logic                emit;
    logic [CpW-1:0]      code_point;
    logic [LenW-1:0]     seq_length;
    status_e             status;
  } result_t;

endpackage

// File: src/utf8d_step.sv
// Decode step of the UTF-8 stream decoder: sequence state and the
// combinational byte decode. Depends on utf8d_pkg.
module utf8d_step (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [utf8d_pkg::ByteW-1:0] byte_i,
  output utf8d_pkg::result_t          result_o
);
  import utf8d_pkg::*;

  logic [CpW-1:0]  partial_q,   partial_d;
  logic [LenW-1:0] remaining_q, remaining_d;
  logic [LenW-1:0] expected_q,  expected_d;
  logic [CpW-1:0]  shifted;
  logic [LenW-1:0] rem_dec;
  logic            is_cont;

  assign is_cont = ((byte_i & LeadMin2) == ContMin);
  assign shifted = {partial_q[CpW-7:0], byte_i[5:0]};
  assign rem_dec = remaining_q - LenW'(1);

  always_comb begin
    partial_d           = partial_q;
    remaining_d         = remaining_q;
    expected_d          = expected_q;
    result_o.emit       = 1'b0;
    result_o.code_point = '0;
    result_o.seq_length = '0;
    result_o.status     = STATUS_OK;
    if (remaining_q != '0) begin
      if (!is_cont) begin
        result_o.emit   = 1'b1;
        result_o.status = STATUS_BAD_CONT;
        partial_d       = '0;
        remaining_d     = '0;
        expected_d      = '0;
      end else if (rem_dec != '0) begin
        partial_d   = shifted;
        remaining_d = rem_dec;
      end else begin
        result_o.emit       = 1'b1;
        result_o.code_point = shifted;
        result_o.seq_length = expected_q;
        partial_d           = '0;
        remaining_d         = '0;
        expected_d          = '0;
      end
    end else if (byte_i < ContMin) begin
      result_o.emit       = 1'b1;
      result_o.code_point = CpW'(byte_i);
      result_o.seq_length = LenW'(1);
    end else if (byte_i < LeadMin2 || byte_i >= InvalidMin) begin
      result_o.emit   = 1'b1;
      result_o.status = STATUS_BAD_LEAD;
    end else if (byte_i >= LeadMin6) begin
      partial_d   = CpW'(byte_i & Lead6Mask);
      expected_d  = LenW'(6);
      remaining_d = LenW'(5);
    end else if (byte_i >= LeadMin5) begin
      partial_d   = CpW'(byte_i & Lead5Mask);
      expected_d  = LenW'(5);
      remaining_d = LenW'(4);
    end else if (byte_i >= LeadMin4) begin
      partial_d   = CpW'(byte_i & Lead4Mask);
      expected_d  = LenW'(4);
      remaining_d = LenW'(3);
    end else if (byte_i >= LeadMin3) begin
      partial_d   = CpW'(byte_i & Lead3Mask);
      expected_d  = LenW'(3);
      remaining_d = LenW'(2);
    end else begin
      partial_d   = CpW'(byte_i & Lead2Mask);
      expected_d  = LenW'(2);
      remaining_d = LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      remaining_q <= '0;
      expected_q  <= '0;
    end else if (step_i) begin
      partial_q   <= partial_d;
      remaining_q <= remaining_d;
      expected_q  <= expected_d;
    end
  end

endmodule

// File: src/utf8_stream_decoder_top.sv
// Top level of the UTF-8 stream decoder: input register, decode step and
// result register with stream handshakes. Depends on utf8d_pkg, utf8d_step.

// The decoder takes one byte of a UTF-8 stream per request and decodes the
// original six-byte form into 31-bit code points. A request is taken on the
// slave side in every cycle while the pipeline moves, so the sustained rate
// is one byte per clock cycle; a byte is held in the input register and its
// result, if any, is written to the result register that drives the master
// side. The single decode step between those registers sets that rate.
// A lead byte or a continuation byte that does not end its
// character produces no result. A finished character gives its code point
// and its length in bytes with status OK. A stray continuation byte or a
// 0xFE or 0xFF byte while idle gives status BAD_LEAD; a byte that is not a
// continuation inside a sequence gives status BAD_CONT and is discarded
// together with the partial character. Error results carry a zero code point
// and length. Overlong forms and surrogates are passed through unchecked, and
// a sequence cut short by the end of the stream simply gives no result.
module utf8_stream_decoder_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [utf8d_pkg::ByteW-1:0]      s_axis_tdata_i,  // [7:0] data_byte
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [30:0] code_point, [33:31] seq_length, [39:34] zero
  output logic [utf8d_pkg::OutTdataW-1:0]  m_axis_tdata_o,
  output logic [utf8d_pkg::StatusW-1:0]    m_axis_tuser_o   // [1:0] status
);
  import utf8d_pkg::*;

  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             advance;
  result_t          step_res;
  logic             out_vld_q, out_vld_d;
  logic [CpW-1:0]   out_cp_q;
  logic [LenW-1:0]  out_len_q;
  status_e          out_status_q;

  // The byte in the input register is decoded once the result register is
  // free or is being emptied in this cycle.
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  utf8d_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .result_o (step_res)
  );

  // The result register keeps its content while the consumer stalls.
  always_comb begin
    out_vld_d = out_vld_q && !m_axis_tready_i;
    if (advance) begin
      out_vld_d = step_res.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step_res.emit) begin
      out_cp_q     <= step_res.code_point;
      out_len_q    <= step_res.seq_length;
      out_status_q <= step_res.status;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(OutTdataW - OutPayW)'(0), out_len_q, out_cp_q};
  assign m_axis_tuser_o  = out_status_q;

  // An error result carries neither code point nor length.
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_status_q != STATUS_OK |-> out_cp_q == '0 && out_len_q == '0)
    else $error("error result with non-zero payload");

  // A good result has a length, and a one-byte character is plain ASCII.
  a_ok_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_status_q == STATUS_OK |-> out_len_q != '0 &&
      (out_len_q != LenW'(1) || out_cp_q < CpW'(ContMin)))
    else $error("good result with inconsistent length");

  // A byte held in the input register stays until it is decoded.
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_byte_q))
    else $error("input byte lost before decode");

  // A stalled result is not overwritten by the next decode.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i |-> !advance)
    else $error("decode while result stalled");

endmodule

// File: tb/utf8_stream_decoder_top_tb.sv
// Self-checking testbench for utf8_stream_decoder_top: byte requests in, decoded characters out.
// Predicts every result with its own decoder model; depends on utf8d_pkg and the decoder RTL.
`timescale 1ns / 1ps

module utf8_stream_decoder_top_tb;
  import utf8d_pkg::*;

  localparam int unsigned RandomBytes = 900;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned IdlePercent = 13;
  localparam int unsigned MaxReports  = 40;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic [LenW-1:0] seq_length;
    status_e         status;
  } char_result_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [ByteW-1:0]     s_axis_tdata_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;
  logic [StatusW-1:0]   m_axis_tuser_o;

  utf8_stream_decoder_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  logic [ByteW-1:0] pending_bytes[$];
  char_result_t     expected_chars[$];

  // Decoder state mirrored from the block's behaviour.
  logic [CpW-1:0]  cp_partial;
  logic [LenW-1:0] cont_due;
  logic [LenW-1:0] char_len;

  int unsigned mismatches;
  int unsigned bytes_taken;
  int unsigned stall_cycles;
  bit          byte_fire;

  // Both sides run without idling for a stretch of the stream.
  wire calm_phase = (bytes_taken >= 350) && (bytes_taken < 550);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Returns 1 when the byte completes a character or raises an error.
  function automatic bit decode_byte(input logic [ByteW-1:0] b, output char_result_t res);
    res = '{code_point: '0, seq_length: '0, status: STATUS_OK};
    if (cont_due != 0) begin
      if (b[7:6] != 2'b10) begin
        cp_partial = '0;
        cont_due   = '0;
        char_len   = '0;
        res.status = STATUS_BAD_CONT;
        return 1'b1;
      end
      cp_partial = {cp_partial[CpW-7:0], b[5:0]};
      cont_due   = cont_due - 1'b1;
      if (cont_due != 0) return 1'b0;
      res.code_point = cp_partial;
      res.seq_length = char_len;
      cp_partial = '0;
      char_len   = '0;
      return 1'b1;
    end
    if (b < ContMin) begin
      res.code_point = CpW'(b);
      res.seq_length = LenW'(1);
      return 1'b1;
    end
    if (b < LeadMin2 || b >= InvalidMin) begin
      res.status = STATUS_BAD_LEAD;
      return 1'b1;
    end
    if (b >= LeadMin6) begin
      char_len = 3'd6; cp_partial = CpW'(b & Lead6Mask);
    end else if (b >= LeadMin5) begin
      char_len = 3'd5; cp_partial = CpW'(b & Lead5Mask);
    end else if (b >= LeadMin4) begin
      char_len = 3'd4; cp_partial = CpW'(b & Lead4Mask);
    end else if (b >= LeadMin3) begin
      char_len = 3'd3; cp_partial = CpW'(b & Lead3Mask);
    end else begin
      char_len = 3'd2; cp_partial = CpW'(b & Lead2Mask);
    end
    cont_due = char_len - 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [ByteW-1:0] lead_byte(input int unsigned len);
    logic [ByteW-1:0] r;
    r = ByteW'($urandom);
    case (len)
      1: lead_byte = {1'b0, r[6:0]};
      2: lead_byte = LeadMin2 | (r & Lead2Mask);
      3: lead_byte = LeadMin3 | (r & Lead3Mask);
      4: lead_byte = LeadMin4 | (r & Lead4Mask);
      5: lead_byte = LeadMin5 | (r & Lead5Mask);
      default: lead_byte = LeadMin6 | (r & Lead6Mask);
    endcase
  endfunction

  function automatic logic [ByteW-1:0] cont_byte();
    return ContMin | (ByteW'($urandom) & ContMask);
  endfunction

  // Anything but a continuation byte: ASCII or any lead, 0xFE and 0xFF included.
  function automatic logic [ByteW-1:0] non_cont_byte();
    logic [ByteW-1:0] r;
    r = ByteW'($urandom);
    if (r[7:6] == 2'b10) r[6] = 1'b1;
    return r;
  endfunction

  task automatic queue_char(input int unsigned len);
    pending_bytes.push_back(lead_byte(len));
    for (int unsigned i = 1; i < len; i++) pending_bytes.push_back(cont_byte());
  endtask

  task automatic queue_bytes(input logic [ByteW-1:0] seq[]);
    foreach (seq[i]) pending_bytes.push_back(seq[i]);
  endtask

  // Request driver: holds a byte until it is taken, otherwise idles at random.
  always @(negedge clk_i) begin
    logic             next_valid;
    logic [ByteW-1:0] next_data;
    next_valid = s_axis_tvalid_i;
    next_data  = s_axis_tdata_i;
    if (rst_ni && (!s_axis_tvalid_i || byte_fire)) begin
      next_valid = 1'b0;
      if (pending_bytes.size() > 0 &&
          (calm_phase || $urandom_range(0, 99) >= IdlePercent)) begin
        next_valid = 1'b1;
        next_data  = pending_bytes.pop_front();
      end
    end
    s_axis_tvalid_i <= next_valid;
    s_axis_tdata_i  <= next_data;
    m_axis_tready_i <= rst_ni && (calm_phase || $urandom_range(0, 99) >= IdlePercent);
  end

  // Monitor: predicts on each accepted byte and checks each accepted result.
  always @(posedge clk_i) begin
    char_result_t pred;
    char_result_t got;
    bit           result_fire;
    byte_fire   = 1'b0;
    result_fire = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        byte_fire = 1'b1;
        bytes_taken++;
        if (decode_byte(s_axis_tdata_i, pred)) expected_chars.push_back(pred);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        result_fire    = 1'b1;
        got.code_point = m_axis_tdata_o[CpW-1:0];
        got.seq_length = m_axis_tdata_o[CpW +: LenW];
        got.status     = status_e'(m_axis_tuser_o);
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: unexpected result, expected none, actual cp=%h len=%0d status=%0d",
                     $time, got.code_point, got.seq_length, got.status);
        end else begin
          pred = expected_chars.pop_front();
          if (got != pred) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("%0t: expected cp=%h len=%0d status=%0d, actual cp=%h len=%0d status=%0d",
                       $time, pred.code_point, pred.seq_length, pred.status,
                       got.code_point, got.seq_length, got.status);
          end
        end
      end
      stall_cycles = (byte_fire || result_fire) ? 0 : stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned len;
    mismatches   = 0;
    bytes_taken  = 0;
    stall_cycles = 0;
    cp_partial   = '0;
    cont_due     = '0;
    char_len     = '0;

    // Directed part: ASCII extremes, stray continuation, invalid leads, lengths two to
    // four and six, the last at the 31-bit maximum, and errors raised inside a sequence.
    queue_bytes('{8'h00, 8'h7F, 8'h80, 8'hFE, 8'hFF});
    queue_bytes('{8'hC2, 8'hA9});
    queue_bytes('{8'hEF, 8'hBF, 8'hBF});
    queue_bytes('{8'hF0, 8'h9F, 8'h98, 8'h80});
    queue_bytes('{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF});
    // An ASCII byte cuts a sequence short and is dropped with it.
    queue_bytes('{8'hE2, 8'h41});
    // A second lead inside a sequence is an error, not a fresh start.
    queue_bytes('{8'hC3, 8'hC3, 8'hBF});

    // Random part: mostly well-formed characters, some noise and broken sequences.
    while (pending_bytes.size() < RandomBytes + 25) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        queue_char($urandom_range(1, 6));
      end else if (pick < 86) begin
        pending_bytes.push_back(ByteW'($urandom));
      end else begin
        len = $urandom_range(2, 6);
        pending_bytes.push_back(lead_byte(len));
        for (int unsigned i = $urandom_range(0, len - 2); i > 0; i--)
          pending_bytes.push_back(cont_byte());
        pending_bytes.push_back(non_cont_byte());
      end
    end
    // The stream ends inside a character, which must give nothing.
    pending_bytes.push_back(lead_byte(4));
    pending_bytes.push_back(cont_byte());

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_bytes.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
